>>> hw/rtl/hbp_pkg.sv
package hbp_pkg;

    // Default table sizes
    localparam int unsigned CHOOSER_INDEX_BITS_DEF = 8;
    localparam int unsigned GSHARE_INDEX_BITS_DEF  = 12;
    localparam int unsigned HISTORY_BITS_DEF       = 8;
    localparam int unsigned BIMODAL_INDEX_BITS_DEF = 10;

    // Stream payload layout
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned CNT_W       = 32;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_FIELD_W = 3 + 2 * CNT_W;
    localparam int unsigned OUT_TDATA_W = 72;

    // Counter encodings
    localparam logic [2:0] CTR_INIT       = 3'd4;
    localparam logic [2:0] CTR_TAKEN_MIN  = 3'd4;
    localparam logic [2:0] CTR_MAX        = 3'd7;
    localparam logic [2:0] CTR_MIN        = 3'd0;
    localparam logic [1:0] CHS_INIT       = 2'd1;
    localparam logic [1:0] CHS_GSHARE_MIN = 2'd2;
    localparam logic [1:0] CHS_MAX        = 2'd3;
    localparam logic [1:0] CHS_MIN        = 2'd0;

    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    // Saturating 3-bit counter step toward the outcome
    function automatic logic [2:0] train_ctr(input logic [2:0] ctr, input logic taken);
        logic [2:0] res;
        res = ctr;
        if (taken) begin
            if (ctr != CTR_MAX) res = ctr + 3'd1;
        end else begin
            if (ctr != CTR_MIN) res = ctr - 3'd1;
        end
        return res;
    endfunction

    // Move chooser toward the component that alone was right
    function automatic logic [1:0] train_chs(input logic [1:0] chs, input logic gsh_ok,
                                             input logic bim_ok);
        logic [1:0] res;
        res = chs;
        if (gsh_ok && !bim_ok) begin
            if (chs != CHS_MAX) res = chs + 2'd1;
        end else if (bim_ok && !gsh_ok) begin
            if (chs != CHS_MIN) res = chs - 2'd1;
        end
        return res;
    endfunction

    // Saturating increment of a running count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
        return (cnt == CNT_SAT) ? cnt : cnt + 1'b1;
    endfunction

endpackage

>>> hw/rtl/hybrid_branch_predictor.sv
// Tournament branch predictor: gshare and bimodal components, per-address chooser.
// Input stream: one resolved branch per transfer, tdata = {pad, actual_taken,
// branch_address}. Output stream: one result per branch, tdata = {pad,
// mispredict_total, prediction_total, used_gshare, mispredicted, predicted_taken}.
// Each accepted branch passes the read stage registers, then the result register.
// Throughput: one branch per cycle unless the output stalls. All three tables take
// a registered read at accept; the chooser and chosen component write back when the
// branch leaves the read stage; a one-entry bypass covers back-to-back same-entry hits.
// Reset: history and counts go to zero, then a clearing pass writes the initial
// counter values into all three tables, one entry per cycle, walking addresses 0 to
// 2**max(chooser, bimodal, gshare index bits) - 1 (4095 with defaults);
// s_axis tready stays low during the pass.
// Stall: the output register holds its result while m_axis tready is low; one
// more branch waits in the read stage, then s_axis tready drops until the
// result is taken.
module hybrid_branch_predictor #(
    parameter int unsigned CHOOSER_INDEX_BITS = hbp_pkg::CHOOSER_INDEX_BITS_DEF,
    parameter int unsigned GSHARE_INDEX_BITS  = hbp_pkg::GSHARE_INDEX_BITS_DEF,
    parameter int unsigned HISTORY_BITS       = hbp_pkg::HISTORY_BITS_DEF,
    parameter int unsigned BIMODAL_INDEX_BITS = hbp_pkg::BIMODAL_INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [31:0] branch_address, [32] actual_taken, [39:33] zero
    input  logic [hbp_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] predicted_taken, [1] mispredicted, [2] used_gshare,
    // [34:3] prediction_total, [66:35] mispredict_total, [71:67] zero
    output logic [hbp_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import hbp_pkg::*;

    localparam int unsigned CW = CHOOSER_INDEX_BITS;
    localparam int unsigned BW = BIMODAL_INDEX_BITS;
    localparam int unsigned GW = GSHARE_INDEX_BITS;
    localparam int unsigned HW = HISTORY_BITS;
    localparam int unsigned CB_W  = (CW > BW) ? CW : BW;
    localparam int unsigned CLR_W = (CB_W > GW) ? CB_W : GW;
    localparam int unsigned OUT_PAD_W = OUT_TDATA_W - OUT_FIELD_W;

    // Tables
    logic [1:0] r_chs_mem [2**CW];
    logic [2:0] r_bim_mem [2**BW];
    logic [2:0] r_gsh_mem [2**GW];

    // Clearing pass
    logic             r_clr_busy;
    logic [CLR_W-1:0] r_clr_addr;

    // Global history
    logic [HW-1:0] r_hist;
    logic [HW-1:0] n_hist;
    logic [GW-1:0] hist_ext;

    // Input decode
    logic          s_acc;
    logic          in_taken;
    logic [CW-1:0] in_ci;
    logic [BW-1:0] in_bi;
    logic [GW-1:0] in_gi;

    // Read stage
    logic          r_s1_valid;
    logic          r_s1_taken;
    logic [CW-1:0] r_s1_ci;
    logic [BW-1:0] r_s1_bi;
    logic [GW-1:0] r_s1_gi;
    logic [1:0]    r_s1_chs_rd;
    logic [2:0]    r_s1_bim_rd;
    logic [2:0]    r_s1_gsh_rd;
    logic          r_chs_byp_hit;
    logic          r_bim_byp_hit;
    logic          r_gsh_byp_hit;
    logic [1:0]    r_chs_byp_val;
    logic [2:0]    r_bim_byp_val;
    logic [2:0]    r_gsh_byp_val;

    // Predict and train
    logic       s1_adv;
    logic [1:0] chs_cur;
    logic [2:0] bim_cur;
    logic [2:0] gsh_cur;
    logic       bim_pred;
    logic       gsh_pred;
    logic       use_gsh;
    logic       pred;
    logic       miss;
    logic [1:0] chs_nxt;
    logic [2:0] bim_nxt;
    logic [2:0] gsh_nxt;
    logic       chs_we;
    logic       bim_we;
    logic       gsh_we;

    // Counts and result register
    logic [CNT_W-1:0]       r_pred_cnt;
    logic [CNT_W-1:0]       r_miss_cnt;
    logic [CNT_W-1:0]       n_pred_cnt;
    logic [CNT_W-1:0]       n_miss_cnt;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Decode the incoming branch
    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_taken = i_s_axis_tdata[ADDR_W];
    assign in_ci    = i_s_axis_tdata[CW+1:2];
    assign in_bi    = i_s_axis_tdata[BW+1:2];
    assign in_gi    = i_s_axis_tdata[GW+1:2] ^ hist_ext;

    // Fit history to the gshare index width
    generate
        if (HW >= GW) begin : g_hist_trim
            assign hist_ext = r_hist[GW-1:0];
        end else begin : g_hist_pad
            assign hist_ext = {{(GW - HW){1'b0}}, r_hist};
        end
        if (HW == 1) begin : g_hist_one
            assign n_hist = in_taken;
        end else begin : g_hist_shift
            assign n_hist = {in_taken, r_hist[HW-1:1]};
        end
    endgenerate

    // Merge bypass with table reads and form the prediction
    always_comb begin
        chs_cur  = r_chs_byp_hit ? r_chs_byp_val : r_s1_chs_rd;
        bim_cur  = r_bim_byp_hit ? r_bim_byp_val : r_s1_bim_rd;
        gsh_cur  = r_gsh_byp_hit ? r_gsh_byp_val : r_s1_gsh_rd;
        bim_pred = bim_cur >= CTR_TAKEN_MIN;
        gsh_pred = gsh_cur >= CTR_TAKEN_MIN;
        use_gsh  = chs_cur >= CHS_GSHARE_MIN;
        pred     = use_gsh ? gsh_pred : bim_pred;
        miss     = pred != r_s1_taken;
        chs_nxt  = train_chs(chs_cur, gsh_pred == r_s1_taken, bim_pred == r_s1_taken);
        bim_nxt  = train_ctr(bim_cur, r_s1_taken);
        gsh_nxt  = train_ctr(gsh_cur, r_s1_taken);
        n_pred_cnt = sat_inc(r_pred_cnt);
        n_miss_cnt = miss ? sat_inc(r_miss_cnt) : r_miss_cnt;
    end

    // Advance when the result register is free or being drained
    assign s1_adv = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign chs_we = s1_adv;
    assign bim_we = s1_adv && !use_gsh;
    assign gsh_we = s1_adv && use_gsh;

    assign o_s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_adv);

    // Chooser table: clear, write back, registered read
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_chs_mem[r_clr_addr[CW-1:0]] <= CHS_INIT;
        end else if (chs_we) begin
            r_chs_mem[r_s1_ci] <= chs_nxt;
        end
        if (s_acc) begin
            r_s1_chs_rd <= r_chs_mem[in_ci];
        end
    end

    // Bimodal table
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_bim_mem[r_clr_addr[BW-1:0]] <= CTR_INIT;
        end else if (bim_we) begin
            r_bim_mem[r_s1_bi] <= bim_nxt;
        end
        if (s_acc) begin
            r_s1_bim_rd <= r_bim_mem[in_bi];
        end
    end

    // Gshare table
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_gsh_mem[r_clr_addr[GW-1:0]] <= CTR_INIT;
        end else if (gsh_we) begin
            r_gsh_mem[r_s1_gi] <= gsh_nxt;
        end
        if (s_acc) begin
            r_s1_gsh_rd <= r_gsh_mem[in_gi];
        end
    end

    // Capture the branch and bypass a write landing in the same cycle
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_taken    <= in_taken;
            r_s1_ci       <= in_ci;
            r_s1_bi       <= in_bi;
            r_s1_gi       <= in_gi;
            r_chs_byp_hit <= chs_we && (r_s1_ci == in_ci);
            r_bim_byp_hit <= bim_we && (r_s1_bi == in_bi);
            r_gsh_byp_hit <= gsh_we && (r_s1_gi == in_gi);
            r_chs_byp_val <= chs_nxt;
            r_bim_byp_val <= bim_nxt;
            r_gsh_byp_val <= gsh_nxt;
        end
    end

    // Control: clearing pass, history, stage valid, counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_hist      <= '0;
            r_s1_valid  <= 1'b0;
            r_pred_cnt  <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == {CLR_W{1'b1}}) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (s_acc) begin
                r_hist     <= n_hist;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_pred_cnt  <= n_pred_cnt;
                r_miss_cnt  <= n_miss_cnt;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, n_miss_cnt, n_pred_cnt, use_gsh, miss, pred};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> hw/rtl/hbp_checker.sv
module hbp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    // [31:0] branch_address, [32] actual_taken, [39:33] zero
    input logic [hbp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    // [0] predicted_taken, [1] mispredicted, [2] used_gshare,
    // [34:3] prediction_total, [66:35] mispredict_total, [71:67] zero
    input logic [hbp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import hbp_pkg::*;

    logic [CNT_W-1:0] pred_total;
    logic [CNT_W-1:0] miss_total;

    assign pred_total = o_m_axis_tdata[CNT_W+2:3];
    assign miss_total = o_m_axis_tdata[2*CNT_W+2:CNT_W+3];

    // Reset starts the clearing pass with both sides quiet
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("ready or valid high right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Every result counts itself, and misses never outrun predictions
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> pred_total != '0 && miss_total <= pred_total)
        else $error("running counts inconsistent");

    // A flagged miss is included in the miss total
    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |-> miss_total != '0)
        else $error("miss not counted");

endmodule

bind hybrid_branch_predictor hbp_checker u_hbp_checker (.*);

>>> test/hybrid_branch_predictor_test.sv
module hybrid_branch_predictor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hbp_pkg::*;

    localparam int unsigned CHS_W  = CHOOSER_INDEX_BITS_DEF;
    localparam int unsigned GSH_W  = GSHARE_INDEX_BITS_DEF;
    localparam int unsigned HIST_W = HISTORY_BITS_DEF;
    localparam int unsigned BIM_W  = BIMODAL_INDEX_BITS_DEF;

    localparam int RANDOM_BRANCHES = 900;
    localparam int WORKING_SET     = 16;
    localparam int IDLE_LIMIT      = 20000;
    localparam int HOLD_CYCLES     = 150;
    localparam int HOLD_AFTER      = 400;
    localparam int DRAIN_CYCLES    = 4;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              taken;
    } t_branch;

    typedef struct packed {
        logic             predicted_taken;
        logic             mispredicted;
        logic             used_gshare;
        logic [CNT_W-1:0] prediction_total;
        logic [CNT_W-1:0] mispredict_total;
    } t_prediction;

    // Outcome behavior of one branch in the synthetic program trace
    typedef enum logic [2:0] {
        ALWAYS_TAKEN,
        NEVER_TAKEN,
        ALTERNATING,
        LOOP_EXIT,
        BIASED
    } t_pattern;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   m_ready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    hybrid_branch_predictor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // [31:0] branch_address, [32] actual_taken, [39:33] zero
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        // [0] predicted_taken, [1] mispredicted, [2] used_gshare,
        // [34:3] prediction_total, [66:35] mispredict_total, [71:67] zero
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Shadow predictor state
    logic [1:0]       chooser_tab [0:(1<<CHS_W)-1];
    logic [2:0]       bimodal_tab [0:(1<<BIM_W)-1];
    logic [2:0]       gshare_tab  [0:(1<<GSH_W)-1];
    logic [HIST_W-1:0] history = '0;
    logic [CNT_W-1:0] branch_count = '0;
    logic [CNT_W-1:0] miss_count = '0;

    t_branch     branch_queue[$];
    t_prediction pending_predictions[$];

    int  error_count = 0;
    int  results_checked = 0;
    int  gshare_picks = 0;
    int  miss_results = 0;
    int  accepted_count = 0;
    int  idle_cycles = 0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    function automatic logic [2:0] step_counter(input logic [2:0] ctr, input logic taken);
        if (taken)
            return (ctr == 3'd7) ? ctr : ctr + 3'd1;
        return (ctr == 3'd0) ? ctr : ctr - 3'd1;
    endfunction

    // Look up both components, pick one, then train and shift history
    task automatic predict_branch(input t_branch br, output t_prediction res);
        logic [29:0]      word;
        logic [CHS_W-1:0] ci;
        logic [BIM_W-1:0] bi;
        logic [GSH_W-1:0] gi;
        logic             bim_taken;
        logic             gsh_taken;
        logic             pick_gshare;
        logic             guess;
        word        = br.addr[31:2];
        ci          = word[CHS_W-1:0];
        bi          = word[BIM_W-1:0];
        gi          = GSH_W'(word ^ 30'(history));
        bim_taken   = bimodal_tab[bi] >= 3'd4;
        gsh_taken   = gshare_tab[gi] >= 3'd4;
        pick_gshare = chooser_tab[ci] >= 2'd2;
        guess       = pick_gshare ? gsh_taken : bim_taken;

        if (branch_count != '1)
            branch_count = branch_count + 1'b1;
        if (guess != br.taken && miss_count != '1)
            miss_count = miss_count + 1'b1;

        if (pick_gshare)
            gshare_tab[gi] = step_counter(gshare_tab[gi], br.taken);
        else
            bimodal_tab[bi] = step_counter(bimodal_tab[bi], br.taken);

        if (gsh_taken == br.taken && bim_taken != br.taken) begin
            if (chooser_tab[ci] != 2'd3)
                chooser_tab[ci] = chooser_tab[ci] + 2'd1;
        end else if (bim_taken == br.taken && gsh_taken != br.taken) begin
            if (chooser_tab[ci] != 2'd0)
                chooser_tab[ci] = chooser_tab[ci] - 2'd1;
        end

        history = (history >> 1) | (HIST_W'(br.taken) << (HIST_W - 1));

        res.predicted_taken  = guess;
        res.mispredicted     = guess != br.taken;
        res.used_gshare      = pick_gshare;
        res.prediction_total = branch_count;
        res.mispredict_total = miss_count;
    endtask

    task automatic report_mismatch(input string field, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
        error_count++;
    endtask

    task automatic add_branch(input logic [ADDR_W-1:0] addr, input logic taken);
        t_branch br;
        br.addr  = addr;
        br.taken = taken;
        branch_queue = {branch_queue, br};
    endtask

    // Mostly short gaps, a few long ones, none at all in steady stretches
    function automatic int idle_length(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Driver: offer queued branches, predict on each transfer
    always @(posedge i_clk) begin
        t_prediction res;
        int          gap;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !o_s_axis_tready)) begin
            gap = tx_gap;
            if (s_valid) begin
                predict_branch(branch_queue[0], res);
                pending_predictions = {pending_predictions, res};
                branch_queue.pop_front();
                accepted_count <= accepted_count + 1;
                if ($urandom_range(0, 49) == 0)
                    tx_steady = !tx_steady;
                gap = (hold_left > 0) ? 0 : idle_length(tx_steady);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                gap--;
            end else if (branch_queue.size() > 0) begin
                s_valid <= 1'b1;
                s_data  <= {7'd0, branch_queue[0].taken, branch_queue[0].addr};
            end else begin
                s_valid <= 1'b0;
            end
            tx_gap = gap;
        end
    end

    // Long receiver hold-off once, partway through the random part
    always @(posedge i_clk) begin
        if (!hold_done && accepted_count >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_prediction want;
        t_prediction got;
        if (o_m_axis_tvalid && m_ready) begin
            got.predicted_taken  = o_m_axis_tdata[0];
            got.mispredicted     = o_m_axis_tdata[1];
            got.used_gshare      = o_m_axis_tdata[2];
            got.prediction_total = o_m_axis_tdata[34:3];
            got.mispredict_total = o_m_axis_tdata[66:35];
            if (pending_predictions.size() == 0) begin
                $display("[%0t] result with no branch outstanding", $realtime);
                error_count++;
            end else begin
                want = pending_predictions.pop_front();
                if (got.predicted_taken != want.predicted_taken)
                    report_mismatch("predicted_taken", CNT_W'(got.predicted_taken),
                                    CNT_W'(want.predicted_taken));
                if (got.mispredicted != want.mispredicted)
                    report_mismatch("mispredicted", CNT_W'(got.mispredicted),
                                    CNT_W'(want.mispredicted));
                if (got.used_gshare != want.used_gshare)
                    report_mismatch("used_gshare", CNT_W'(got.used_gshare),
                                    CNT_W'(want.used_gshare));
                if (got.prediction_total != want.prediction_total)
                    report_mismatch("prediction_total", got.prediction_total,
                                    want.prediction_total);
                if (got.mispredict_total != want.mispredict_total)
                    report_mismatch("mispredict_total", got.mispredict_total,
                                    want.mispredict_total);
                results_checked++;
                gshare_picks += int'(want.used_gshare);
                miss_results += int'(want.mispredicted);
            end
        end

        // Stall the output at random, and fully during the hold-off
        if (rx_stall > 0) begin
            rx_stall--;
        end else begin
            if ($urandom_range(0, 99) == 0)
                rx_steady = !rx_steady;
            if ($urandom_range(0, 99) < 25)
                rx_stall = idle_length(rx_steady);
        end
        m_ready <= (rx_stall == 0) && (hold_left == 0);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] timeout: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [ADDR_W-1:0] ws_addr  [WORKING_SET];
        t_pattern          ws_kind  [WORKING_SET];
        int                ws_trip  [WORKING_SET];
        int                ws_step  [WORKING_SET];
        int                body     [8];
        int                body_len;
        int                reps;
        int                produced;
        int                idx;
        logic              outcome;

        for (int i = 0; i < (1 << CHS_W); i++)
            chooser_tab[i] = 2'd1;
        for (int i = 0; i < (1 << BIM_W); i++)
            bimodal_tab[i] = 3'd4;
        for (int i = 0; i < (1 << GSH_W); i++)
            gshare_tab[i] = 3'd4;

        // Directed: address extremes, ignored low bits, saturation, aliasing
        add_branch(32'h0000_0000, 1'b1);
        add_branch(32'hFFFF_FFFF, 1'b0);
        add_branch(32'hFFFF_FFFC, 1'b1);
        add_branch(32'h0000_0003, 1'b0);
        repeat (5) add_branch(32'h1000_0040, 1'b1);
        repeat (8) add_branch(32'h1000_0040, 1'b0);
        add_branch(32'h2000_0040, 1'b1);
        add_branch(32'h8000_0000, 1'b1);
        add_branch(32'h7FFF_FFFF, 1'b0);
        add_branch(32'hAAAA_AAAA, 1'b1);
        add_branch(32'h5555_5555, 1'b0);

        // Working set of branches, odd ones aliasing their neighbor's low index bits
        for (int i = 0; i < WORKING_SET; i++) begin
            if (i % 2 == 1)
                ws_addr[i] = ws_addr[i-1] ^ ($urandom_range(1, 1023) << 14);
            else
                ws_addr[i] = $urandom();
            ws_kind[i] = t_pattern'($urandom_range(0, 4));
            ws_trip[i] = $urandom_range(2, 9);
            ws_step[i] = 0;
        end

        // Random: loop bodies of working-set branches, with some noise
        produced = 0;
        while (produced < RANDOM_BRANCHES) begin
            if ($urandom_range(0, 9) < 2) begin
                repeat ($urandom_range(1, 6)) begin
                    add_branch($urandom(), 1'($urandom_range(0, 1)));
                    produced++;
                end
            end else begin
                body_len = $urandom_range(2, 8);
                for (int j = 0; j < body_len; j++)
                    body[j] = $urandom_range(0, WORKING_SET - 1);
                reps = $urandom_range(4, 20);
                repeat (reps) begin
                    for (int j = 0; j < body_len; j++) begin
                        idx = body[j];
                        case (ws_kind[idx])
                            ALWAYS_TAKEN: outcome = 1'b1;
                            NEVER_TAKEN:  outcome = 1'b0;
                            ALTERNATING:  outcome = ws_step[idx][0];
                            LOOP_EXIT:    outcome = (ws_step[idx] % ws_trip[idx]) != 0;
                            default:      outcome = $urandom_range(0, 9) < 8;
                        endcase
                        ws_step[idx]++;
                        add_branch(ws_addr[idx], outcome);
                        produced++;
                    end
                end
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every branch to transfer, then for every result
        while (branch_queue.size() > 0 || s_valid)
            @(posedge i_clk);
        while (pending_predictions.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        foreach (pending_predictions[i]) begin
            $display("result never arrived for branch #%0d",
                     pending_predictions[i].prediction_total);
            error_count++;
        end

        $display("Checked %0d results from %0d branches: %0d gshare picks, %0d mispredicts",
                 results_checked, accepted_count, gshare_picks, miss_results);
        $display("Output hold-off of %0d cycles %0s; %0d errors", HOLD_CYCLES,
                 hold_done ? "applied" : "not reached", error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
